/* hdl/cmfs_pkg.sv */
// shared types and constants for cube map face selection
package cmfs_pkg;

	localparam int DIR_BITS_DEF      = 16;
	localparam int MAX_FACE_SIZE_DEF = 4096;
	localparam int REG_W             = 13;
	localparam int CFG_IDX_W         = 1;

	localparam logic [REG_W-1:0] SIZE_RESET = 13'd16;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACE_WIDTH  = 1'b0,
		REG_FACE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic  vld;
		face_t face;
		logic  zero;
	} side_t;

endpackage

/* hdl/cmfs_if.sv */
// word channels: direction in, face and texel address out
interface cmfs_dir_if import cmfs_pkg::*; #(
	parameter int DIR_BITS = DIR_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [DIR_BITS-1:0] dir_x;
	logic signed [DIR_BITS-1:0] dir_y;
	logic signed [DIR_BITS-1:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_res_if import cmfs_pkg::*; #(
	parameter int TEXEL_W = 12
);
	logic               valid;
	logic               ready;
	face_t              face;
	logic [TEXEL_W-1:0] texel_col;
	logic [TEXEL_W-1:0] texel_row;
	logic               zero_vector;

	modport source (output valid, output face, output texel_col, output texel_row,
		output zero_vector, input ready);
	modport sink (input valid, input face, input texel_col, input texel_row,
		input zero_vector, output ready);
endinterface

/* hdl/cmfs_major.sv */
// magnitudes, major axis pick and biased face coordinates
module cmfs_major import cmfs_pkg::*; #(
	parameter int DIR_BITS = DIR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic signed [DIR_BITS-1:0] x,
	input  logic signed [DIR_BITS-1:0] y,
	input  logic signed [DIR_BITS-1:0] z,
	output side_t                      side_s2,
	output logic [DIR_BITS-1:0]        ma_s2,
	output logic [DIR_BITS:0]          sum_sc_s2,
	output logic [DIR_BITS:0]          sum_tc_s2
);

	localparam int EW = DIR_BITS + 2;

	function automatic logic [DIR_BITS-1:0] mag(input logic signed [DIR_BITS-1:0] v);
		logic signed [DIR_BITS-1:0] n;
		n = -v;
		return v[DIR_BITS-1] ? n : v;
	endfunction

	logic                       vld_s1;
	logic signed [DIR_BITS-1:0] x_s1, y_s1, z_s1;
	logic [DIR_BITS-1:0]        ax_s1, ay_s1, az_s1;

	side_t                      side_d;
	logic [DIR_BITS-1:0]        ma_d;
	logic signed [EW-1:0]       xe, ye, ze, mae, sc_d, tc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			side_s2 <= '0;
		end else if (en) begin
			vld_s1  <= in_vld;
			side_s2 <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1      <= x;
			y_s1      <= y;
			z_s1      <= z;
			ax_s1     <= mag(x);
			ay_s1     <= mag(y);
			az_s1     <= mag(z);
			ma_s2     <= ma_d;
			sum_sc_s2 <= sc_d[DIR_BITS:0];
			sum_tc_s2 <= tc_d[DIR_BITS:0];
		end
	end

	always_comb begin
		xe  = EW'(x_s1);
		ye  = EW'(y_s1);
		ze  = EW'(z_s1);
		side_d.vld  = vld_s1;
		side_d.zero = (ax_s1 == '0) && (ay_s1 == '0) && (az_s1 == '0);
		if (ax_s1 >= ay_s1 && ax_s1 >= az_s1) begin
			ma_d = ax_s1;
			mae  = $signed({2'b00, ma_d});
			tc_d = mae - ye;
			if (x_s1[DIR_BITS-1]) begin
				side_d.face = FACE_NEG_X;
				sc_d        = mae + ze;
			end else begin
				side_d.face = FACE_POS_X;
				sc_d        = mae - ze;
			end
		end else if (ay_s1 >= az_s1) begin
			ma_d = ay_s1;
			mae  = $signed({2'b00, ma_d});
			sc_d = mae + xe;
			if (y_s1[DIR_BITS-1]) begin
				side_d.face = FACE_NEG_Y;
				tc_d        = mae - ze;
			end else begin
				side_d.face = FACE_POS_Y;
				tc_d        = mae + ze;
			end
		end else begin
			ma_d = az_s1;
			mae  = $signed({2'b00, ma_d});
			tc_d = mae - ye;
			if (z_s1[DIR_BITS-1]) begin
				side_d.face = FACE_NEG_Z;
				sc_d        = mae - xe;
			end else begin
				side_d.face = FACE_POS_Z;
				sc_d        = mae + xe;
			end
		end
	end

endmodule

/* hdl/cmfs_texel.sv */
// one texel coordinate: scale, pipelined restoring divide, clamp
module cmfs_texel import cmfs_pkg::*; #(
	parameter int DIR_BITS = DIR_BITS_DEF,
	parameter int SIZE_W   = 13,
	parameter int TEXEL_W  = 12
) (
	input  logic                clk,
	input  logic                en,
	input  logic [DIR_BITS:0]   sum,
	input  logic [DIR_BITS-1:0] ma,
	input  logic [SIZE_W-1:0]   size,
	output logic [TEXEL_W-1:0]  texel_q
);

	localparam int NUM_W = DIR_BITS + 1 + SIZE_W;

	logic [NUM_W-1:0]  rem_sd [SIZE_W];
	logic [DIR_BITS:0] den_sd [SIZE_W];
	logic [SIZE_W-1:0] quo_sd [SIZE_W+1];
	logic [SIZE_W-1:0] lim;

	assign quo_sd[0] = '0;
	assign lim       = size - SIZE_W'(1);

	// scale stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= NUM_W'(sum) * NUM_W'(size);
			den_sd[0] <= {ma, 1'b0};
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < SIZE_W; k++) begin : g_div
		localparam int B = SIZE_W - 1 - k;
		logic [NUM_W-1:0] shd;
		logic             ge;

		assign shd = NUM_W'(den_sd[k]) << B;
		assign ge  = rem_sd[k] >= shd;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_sd[k+1] <= quo_sd[k] | (SIZE_W'(ge) << B);
			end
		end

		if (k < SIZE_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[k+1] <= ge ? rem_sd[k] - shd : rem_sd[k];
					den_sd[k+1] <= den_sd[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			texel_q <= (quo_sd[SIZE_W] > lim) ? TEXEL_W'(lim) : TEXEL_W'(quo_sd[SIZE_W]);
		end
	end

endmodule

/* hdl/cube_map_face_select_core.sv */
// Cube map face selection with texel addressing. One direction word is taken
// every cycle while no result word is held at the output. Each texel
// coordinate is found by an exact divide (SIZE_W = clog2(MAX_FACE_SIZE + 1)),
// a restoring divider with one quotient bit per register stage, one for
// columns and one for rows, ahead of which sit two stages of axis selection
// and one multiply stage, and behind which sits one clamp stage. The
// pipeline stalls as a whole only while a result word waits at the output.
// Face sizes are written over the cfg port: index 0 width, index 1 height,
// zero read as 1, values above MAX_FACE_SIZE saturate. Write them only while
// no word is in flight.
module cube_map_face_select_core import cmfs_pkg::*; #(
	parameter int DIR_BITS      = DIR_BITS_DEF,
	parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [REG_W-1:0]     cfg_data,
	cmfs_dir_if.sink             dirs,
	cmfs_res_if.source           res
);

	localparam int SIZE_W  = $clog2(MAX_FACE_SIZE + 1);
	localparam int TEXEL_W = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1;

	logic [REG_W-1:0]    width_q, height_q;
	logic [SIZE_W-1:0]   size_col, size_row;
	logic                en;

	side_t               side_s2;
	logic [DIR_BITS-1:0] ma_s2;
	logic [DIR_BITS:0]   sum_sc_s2, sum_tc_s2;
	side_t               side_sl [SIZE_W+2];
	side_t               side_out;
	logic [TEXEL_W-1:0]  col_q, row_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_FACE_WIDTH:  width_q  <= cfg_data;
				REG_FACE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			size_col = SIZE_W'(1);
		end else if (32'(width_q) > MAX_FACE_SIZE) begin
			size_col = SIZE_W'(MAX_FACE_SIZE);
		end else begin
			size_col = SIZE_W'(width_q);
		end
		if (height_q == '0) begin
			size_row = SIZE_W'(1);
		end else if (32'(height_q) > MAX_FACE_SIZE) begin
			size_row = SIZE_W'(MAX_FACE_SIZE);
		end else begin
			size_row = SIZE_W'(height_q);
		end
	end

	assign en         = !side_out.vld || res.ready;
	assign dirs.ready = en;

	cmfs_major #(
		.DIR_BITS(DIR_BITS)
	) u_major (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dirs.valid),
		.x        (dirs.dir_x),
		.y        (dirs.dir_y),
		.z        (dirs.dir_z),
		.side_s2  (side_s2),
		.ma_s2    (ma_s2),
		.sum_sc_s2(sum_sc_s2),
		.sum_tc_s2(sum_tc_s2)
	);

	cmfs_texel #(
		.DIR_BITS(DIR_BITS),
		.SIZE_W  (SIZE_W),
		.TEXEL_W (TEXEL_W)
	) u_col (
		.clk    (clk),
		.en     (en),
		.sum    (sum_sc_s2),
		.ma     (ma_s2),
		.size   (size_col),
		.texel_q(col_q)
	);

	cmfs_texel #(
		.DIR_BITS(DIR_BITS),
		.SIZE_W  (SIZE_W),
		.TEXEL_W (TEXEL_W)
	) u_row (
		.clk    (clk),
		.en     (en),
		.sum    (sum_tc_s2),
		.ma     (ma_s2),
		.size   (size_row),
		.texel_q(row_q)
	);

	// face, zero flag and valid ride alongside the divide lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIZE_W + 2; k++) begin
				side_sl[k] <= '0;
			end
		end else if (en) begin
			side_sl[0] <= side_s2;
			for (int k = 1; k < SIZE_W + 2; k++) begin
				side_sl[k] <= side_sl[k-1];
			end
		end
	end

	assign side_out        = side_sl[SIZE_W+1];
	assign res.valid       = side_out.vld;
	assign res.face        = side_out.face;
	assign res.zero_vector = side_out.zero;
	assign res.texel_col   = side_out.zero ? '0 : col_q;
	assign res.texel_row   = side_out.zero ? '0 : row_q;

`ifndef ASSERT_OFF
	a_col_in_face: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (SIZE_W'(res.texel_col) < size_col))
		else $error("texel column beyond face width");

	a_row_in_face: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (SIZE_W'(res.texel_row) < size_row))
		else $error("texel row beyond face height");

	a_zero_default: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.zero_vector) |->
			(res.face == FACE_POS_X && res.texel_col == '0 && res.texel_row == '0))
		else $error("zero vector result not defaulted");
`endif

endmodule
